### rtl/core/odc_pkg.sv
// Package for the obstacle danger classifier.
// Holds the danger level codes, register indexes, the register file type and
// the classifier result struct. It depends on nothing.
`default_nettype none

package odc_pkg;

  typedef enum logic [2:0] {
    LVL_SAFE      = 3'd0,
    LVL_CAUTION   = 3'd1,
    LVL_AVOID     = 3'd2,
    LVL_EMERGENCY = 3'd3,
    LVL_BLOCKED   = 3'd4,
    LVL_UNKNOWN   = 3'd5
  } level_t;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_CAUTION_DIST = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AVOID_DIST   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EMERG_DIST   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HYST_MARGIN  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CONF_FLOOR   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TOUT_TOL     = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FEATURES     = 4'd7;

  localparam int unsigned FEAT_VEL_OVR = 0;
  localparam int unsigned FEAT_CONF    = 1;
  localparam int unsigned FEAT_STABLE  = 2;
  localparam int unsigned FEAT_MEMORY  = 3;

  localparam logic [15:0] CNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [15:0]        caution_distance;
    logic [15:0]        avoid_distance;
    logic [15:0]        emergency_distance;
    logic [15:0]        hysteresis_margin;
    logic signed [15:0] closing_speed_limit;
    logic [7:0]         confidence_floor;
    logic [7:0]         timeout_tolerance;
    logic [3:0]         feature_enables;
  } cfg_t;

  typedef struct packed {
    level_t level;
    logic   valid;
    logic   healthy;
  } cls_t;

endpackage

`default_nettype wire

### rtl/core/odc_classify.sv
// Combinational health check, obstacle gating, distance classification and
// hysteresis against the previous level. Depends on odc_pkg.
`default_nettype none

module odc_classify (
  input  odc_pkg::cfg_t      cfg,
  input  odc_pkg::level_t    prev_level,
  input  logic [15:0]        distance,
  input  logic signed [15:0] velocity,
  input  logic [7:0]         confidence,
  input  logic               stable,
  input  logic [7:0]         timeout_run,
  output odc_pkg::cls_t      cls
);
  import odc_pkg::*;

  logic        healthy;
  logic        valid;
  level_t      raw_level;
  level_t      hyst_level;
  logic [16:0] emerg_lim;
  logic [16:0] avoid_lim;
  logic [16:0] caution_lim;
  logic [16:0] dist_x;
  logic        take_new;

  assign healthy = timeout_run < cfg.timeout_tolerance;
  assign valid   = healthy && (distance <= cfg.caution_distance)
                 && !(cfg.feature_enables[FEAT_CONF] && (confidence < cfg.confidence_floor))
                 && !(cfg.feature_enables[FEAT_STABLE] && !stable);

  always_comb begin
    if (cfg.feature_enables[FEAT_VEL_OVR] && (velocity < cfg.closing_speed_limit)) begin
      raw_level = LVL_EMERGENCY;
    end else if (distance <= cfg.emergency_distance) begin
      raw_level = LVL_EMERGENCY;
    end else if (distance <= cfg.avoid_distance) begin
      raw_level = LVL_AVOID;
    end else if (distance <= cfg.caution_distance) begin
      raw_level = LVL_CAUTION;
    end else begin
      raw_level = LVL_SAFE;
    end
  end

  assign dist_x      = {1'b0, distance};
  assign emerg_lim   = {1'b0, cfg.emergency_distance} + {1'b0, cfg.hysteresis_margin};
  assign avoid_lim   = {1'b0, cfg.avoid_distance} + {1'b0, cfg.hysteresis_margin};
  assign caution_lim = {1'b0, cfg.caution_distance} + {1'b0, cfg.hysteresis_margin};

  // Unknown is checked explicitly, so any new level replaces it.
  assign take_new = (prev_level == LVL_UNKNOWN) || (raw_level > prev_level);

  always_comb begin
    hyst_level = raw_level;
    if (!take_new) begin
      if ((prev_level == LVL_EMERGENCY) && (dist_x <= emerg_lim)) begin
        hyst_level = LVL_EMERGENCY;
      end else if ((prev_level == LVL_AVOID) && (dist_x <= avoid_lim)) begin
        hyst_level = LVL_AVOID;
      end else if ((prev_level == LVL_CAUTION) && (dist_x <= caution_lim)) begin
        hyst_level = LVL_CAUTION;
      end
    end
  end

  always_comb begin
    cls.healthy = healthy;
    cls.valid   = valid;
    if (!healthy) begin
      cls.level = LVL_UNKNOWN;
    end else if (valid) begin
      cls.level = hyst_level;
    end else begin
      cls.level = LVL_SAFE;
    end
  end

endmodule

`default_nettype wire

### rtl/core/odc_track.sv
// Track state (detect and lost counters, last sighting, previous level) and
// the result register. Updates once per request. Depends on odc_pkg.
`default_nettype none

module odc_track #(
  parameter int unsigned BLOCKED_FRAMES   = 20,
  parameter int unsigned MIN_DETECT_FRAMES = 3,
  parameter int unsigned MAX_LOST_FRAMES  = 5,
  parameter int unsigned MEMORY_WINDOW_MS = 1000
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            out_stall,
  input  logic            mem_en,
  input  odc_pkg::cls_t   cls,
  input  logic [31:0]     time_ms,
  output odc_pkg::level_t prev_level,
  output logic            out_valid,
  output logic [2:0]      out_danger,
  output logic            out_detected,
  output logic            out_healthy,
  output logic            out_emergency_flag,
  output logic            out_remembered,
  output logic            out_confirmed,
  output logic            out_active
);
  import odc_pkg::*;

  localparam logic [15:0] BLK_C  = 16'(BLOCKED_FRAMES);
  localparam logic [15:0] MIN_C  = 16'(MIN_DETECT_FRAMES);
  localparam logic [15:0] LOST_C = 16'(MAX_LOST_FRAMES);
  localparam logic [31:0] WIN_C  = 32'(MEMORY_WINDOW_MS);

  level_t      prev_r, prev_nxt;
  logic [15:0] det_r, det_nxt;
  logic [15:0] lost_r, lost_nxt;
  logic [31:0] seen_r, seen_nxt;
  logic        act_r, act_nxt;
  logic        stb_r, stb_nxt;
  logic        vld_r, vld_nxt;
  logic [15:0] det_inc;
  logic [15:0] lost_inc;
  logic [31:0] age;
  logic        emerg;
  level_t      final_level;

  logic [2:0]  danger_r;
  logic        det_flag_r, healthy_r, emerg_r, rem_r, conf_r, active_r;

  assign det_inc  = (det_r != CNT_MAX) ? det_r + 16'd1 : det_r;
  assign lost_inc = (lost_r != CNT_MAX) ? lost_r + 16'd1 : lost_r;

  always_comb begin
    prev_nxt = prev_r;
    det_nxt  = det_r;
    lost_nxt = lost_r;
    seen_nxt = seen_r;
    act_nxt  = act_r;
    stb_nxt  = stb_r;
    if (cls.valid) begin
      det_nxt  = det_inc;
      lost_nxt = 16'd0;
      seen_nxt = time_ms;
      act_nxt  = 1'b1;
      stb_nxt  = det_inc >= MIN_C;
    end else begin
      lost_nxt = lost_inc;
      if (lost_inc > LOST_C) begin
        act_nxt = 1'b0;
        stb_nxt = 1'b0;
        det_nxt = 16'd0;
      end
    end
    emerg       = cls.level == LVL_EMERGENCY;
    final_level = (emerg && (det_nxt >= BLK_C)) ? LVL_BLOCKED : cls.level;
    prev_nxt    = final_level;
    age         = time_ms - seen_nxt;
  end

  assign vld_nxt = adv || (vld_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= LVL_SAFE;
      det_r  <= 16'd0;
      lost_r <= 16'd0;
      seen_r <= 32'd0;
      act_r  <= 1'b0;
      stb_r  <= 1'b0;
      vld_r  <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      if (adv) begin
        prev_r <= prev_nxt;
        det_r  <= det_nxt;
        lost_r <= lost_nxt;
        seen_r <= seen_nxt;
        act_r  <= act_nxt;
        stb_r  <= stb_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      danger_r   <= final_level;
      det_flag_r <= cls.valid;
      healthy_r  <= cls.healthy;
      emerg_r    <= emerg;
      rem_r      <= mem_en && (age <= WIN_C);
      conf_r     <= stb_nxt;
      active_r   <= act_nxt;
    end
  end

  assign prev_level         = prev_r;
  assign out_valid          = vld_r;
  assign out_danger         = danger_r;
  assign out_detected       = det_flag_r;
  assign out_healthy        = healthy_r;
  assign out_emergency_flag = emerg_r;
  assign out_remembered     = rem_r;
  assign out_confirmed      = conf_r;
  assign out_active         = active_r;

endmodule

`default_nettype wire

### rtl/core/obstacle_danger_classifier.sv
// Obstacle danger classifier, top level.
// Every request carries one filtered range sample: distance, closing
// velocity, confidence, stable flag, timeout run and a millisecond timestamp.
// Each request yields exactly one result: the danger level, the detected,
// healthy and emergency flags, the memory flag, and the track state.
// Both channels use valid and stall; a request moves when valid is high and
// stall is low. Configuration writes use cfg_wr_en, cfg_index and cfg_wdata
// and must be made only while no request is in flight, which the block does
// not enforce; indexes above 7 are ignored.
// A request is held in an input register, then classified and folded into
// the track state combinationally on its way into the result register, so
// it passes through the input register and then the result register, and
// one request is taken every cycle while the receiver does not stall. The
// loop through the previous level and the counters closes in that step.
// When the receiver stalls, the result register holds; the input register
// still takes one more request, and in_stall rises only when both are full.
// Synchronous reset loads the register defaults, sets the previous level to
// safe, clears the counters and track flags and empties both registers.
// Depends on odc_pkg, odc_classify and odc_track.
`default_nettype none

module obstacle_danger_classifier #(
  parameter int unsigned BLOCKED_FRAMES    = 20,
  parameter int unsigned MIN_DETECT_FRAMES = 3,
  parameter int unsigned MAX_LOST_FRAMES   = 5,
  parameter int unsigned MEMORY_WINDOW_MS  = 1000
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [odc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [odc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [15:0]                      in_distance,
  input  logic signed [15:0]               in_velocity,
  input  logic [7:0]                       in_confidence,
  input  logic                             in_stable,
  input  logic [7:0]                       in_timeout_run,
  input  logic [31:0]                      in_time_ms,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [2:0]                       out_danger,
  output logic                             out_detected,
  output logic                             out_healthy,
  output logic                             out_emergency_flag,
  output logic                             out_remembered,
  output logic                             out_confirmed,
  output logic                             out_active
);
  import odc_pkg::*;

  cfg_t               cfg_r;
  logic               s1_vld_r, s1_vld_nxt;
  logic [15:0]        dist_r;
  logic signed [15:0] vel_r;
  logic [7:0]         conf_r;
  logic               stable_r;
  logic [7:0]         tout_r;
  logic [31:0]        time_r;
  logic               in_acc;
  logic               adv;
  level_t             prev_level;
  cls_t               cls;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.caution_distance    <= 16'd1600;
      cfg_r.avoid_distance      <= 16'd800;
      cfg_r.emergency_distance  <= 16'd320;
      cfg_r.hysteresis_margin   <= 16'd80;
      cfg_r.closing_speed_limit <= -16'sd800;
      cfg_r.confidence_floor    <= 8'd128;
      cfg_r.timeout_tolerance   <= 8'd3;
      cfg_r.feature_enables     <= 4'hF;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_CAUTION_DIST: cfg_r.caution_distance    <= cfg_wdata;
        REG_AVOID_DIST:   cfg_r.avoid_distance      <= cfg_wdata;
        REG_EMERG_DIST:   cfg_r.emergency_distance  <= cfg_wdata;
        REG_HYST_MARGIN:  cfg_r.hysteresis_margin   <= cfg_wdata;
        REG_SPEED_LIMIT:  cfg_r.closing_speed_limit <= cfg_wdata;
        REG_CONF_FLOOR:   cfg_r.confidence_floor    <= cfg_wdata[7:0];
        REG_TOUT_TOL:     cfg_r.timeout_tolerance   <= cfg_wdata[7:0];
        REG_FEATURES:     cfg_r.feature_enables     <= cfg_wdata[3:0];
        default: begin
        end
      endcase
    end
  end

  assign adv        = s1_vld_r && (!out_valid || !out_stall);
  assign in_stall   = s1_vld_r && !adv;
  assign in_acc     = in_valid && !in_stall;
  assign s1_vld_nxt = in_acc || (s1_vld_r && !adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      dist_r   <= in_distance;
      vel_r    <= in_velocity;
      conf_r   <= in_confidence;
      stable_r <= in_stable;
      tout_r   <= in_timeout_run;
      time_r   <= in_time_ms;
    end
  end

  odc_classify u_classify (
    .cfg         (cfg_r),
    .prev_level  (prev_level),
    .distance    (dist_r),
    .velocity    (vel_r),
    .confidence  (conf_r),
    .stable      (stable_r),
    .timeout_run (tout_r),
    .cls         (cls)
  );

  odc_track #(
    .BLOCKED_FRAMES    (BLOCKED_FRAMES),
    .MIN_DETECT_FRAMES (MIN_DETECT_FRAMES),
    .MAX_LOST_FRAMES   (MAX_LOST_FRAMES),
    .MEMORY_WINDOW_MS  (MEMORY_WINDOW_MS)
  ) u_track (
    .clk                (clk),
    .rst_n              (rst_n),
    .adv                (adv),
    .out_stall          (out_stall),
    .mem_en             (cfg_r.feature_enables[FEAT_MEMORY]),
    .cls                (cls),
    .time_ms            (time_r),
    .prev_level         (prev_level),
    .out_valid          (out_valid),
    .out_danger         (out_danger),
    .out_detected       (out_detected),
    .out_healthy        (out_healthy),
    .out_emergency_flag (out_emergency_flag),
    .out_remembered     (out_remembered),
    .out_confirmed      (out_confirmed),
    .out_active         (out_active)
  );

endmodule

`default_nettype wire

### rtl/core/odc_checker.sv
// Port-level checks for the obstacle danger classifier and the bind that
// attaches them to the top level. Depends on odc_pkg.
`default_nettype none

module odc_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [2:0] out_danger,
  input  logic       out_detected,
  input  logic       out_healthy,
  input  logic       out_emergency_flag,
  input  logic       out_confirmed,
  input  logic       out_active
);
  import odc_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_danger))
    else $error("result changed while stalled");

  a_unhealthy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_healthy |-> out_danger == LVL_UNKNOWN && !out_detected)
    else $error("unhealthy sensor without unknown level");

  a_detect_track: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_detected |-> out_active && out_healthy)
    else $error("detection without active track");

  a_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_danger == LVL_BLOCKED |-> out_emergency_flag && out_detected
      && out_confirmed)
    else $error("blocked without confirmed emergency");

  a_emerg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_emergency_flag |->
      out_danger == LVL_EMERGENCY || out_danger == LVL_BLOCKED)
    else $error("emergency flag with wrong level");

endmodule

bind obstacle_danger_classifier odc_checker u_odc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_danger         (out_danger),
  .out_detected       (out_detected),
  .out_healthy        (out_healthy),
  .out_emergency_flag (out_emergency_flag),
  .out_confirmed      (out_confirmed),
  .out_active         (out_active)
);

`default_nettype wire
